// File: rtl/lpfr_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lpfr_pkg
// Shared constants, types and helpers of the length-prefixed frame receiver.
// -----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 64;
    localparam int LEN_CAP              = 63;
    localparam int FRAME_OVERHEAD       = 3;

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET   = 8'h55;
    localparam logic [7:0] KEY_FUNCTION = 8'h01;
    localparam logic [7:0] KEY_OFF      = 8'h00;
    localparam logic [7:0] KEY_ON       = 8'h01;

    // configuration register indexes
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_TAIL   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_len;
        logic store_byte;
        logic start_emit;
        logic emit_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hdr_match;
        logic len_ok;
        logic data_done;
        logic tail_match;
        logic emit_last;
        logic out_free;
    } sts_t;

    // longest payload the store holds
    function automatic int len_limit(input int buffer_bytes);
        int lim;
        begin
            lim = (buffer_bytes > FRAME_OVERHEAD) ? buffer_bytes - FRAME_OVERHEAD : 0;
            len_limit = (lim > LEN_CAP) ? LEN_CAP : lim;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/lpfr_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lpfr_ctrl
// Frame state machine: hunt, length, payload, tail and burst out.
// -----------------------------------------------------------------------------
module lpfr_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire lpfr_pkg::sts_t sts,
    output lpfr_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_TAIL = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_stall = (state_reg == ST_EMIT);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_len   = 1'b0;
        cmd.store_byte = 1'b0;
        cmd.start_emit = 1'b0;
        cmd.emit_step  = 1'b0;
        case (state_reg)
            ST_HUNT:
            begin
                if (accept && sts.hdr_match)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = ST_DATA;
                    end
                    else
                        state_next = ST_HUNT;
                end
            end
            ST_DATA:
            begin
                if (accept)
                begin
                    cmd.store_byte = 1'b1;
                    if (sts.data_done)
                        state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                // a wrong tail drops the frame
                if (accept)
                begin
                    if (sts.tail_match)
                    begin
                        cmd.start_emit = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                        state_next = ST_HUNT;
                end
            end
            ST_EMIT:
            begin
                // advance one beat whenever the output register frees up
                if (sts.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (sts.emit_last)
                        state_next = ST_HUNT;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: rtl/lpfr_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lpfr_dp
// Datapath: configuration registers, length and count, payload store,
// key command decode and the output register.
// -----------------------------------------------------------------------------
module lpfr_dp
#(
    parameter int BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEFAULT
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    input  wire logic           cfg_index,
    input  wire logic [7:0]     cfg_data,
    input  wire logic [7:0]     rx_byte,
    input  wire lpfr_pkg::cmd_t cmd,
    output lpfr_pkg::sts_t      sts,
    input  wire logic           out_stall,
    output logic                out_valid,
    output logic [7:0]          payload_byte,
    output logic [5:0]          payload_position,
    output logic                last_of_frame,
    output logic                key_command_valid,
    output logic                key_on
);

    localparam int LIM = lpfr_pkg::len_limit(BUFFER_BYTES);
    localparam int AW  = (LIM > 1) ? $clog2(LIM) : 1;

    logic [7:0]    header_reg;
    logic [7:0]    tail_reg;
    logic [5:0]    len_reg;
    logic [5:0]    cnt_reg;
    logic          b0_fn_reg;
    logic          b1_le1_reg;
    logic          b1_one_reg;
    logic [7:0]    store_mem [0:LIM-1];
    logic [7:0]    rd_data_reg;
    logic [5:0]    pos_reg;
    logic          last_reg;
    logic          kv_reg;
    logic          kon_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [AW-1:0] addr;
    logic [6:0]    cnt_inc;
    logic          key_valid;

    assign addr    = cnt_reg[AW-1:0];
    assign cnt_inc = {1'b0, cnt_reg} + 7'd1;

    assign sts.hdr_match  = (rx_byte == header_reg);
    assign sts.len_ok     = (rx_byte != 8'd0) && (rx_byte <= 8'(LIM));
    assign sts.data_done  = (cnt_inc == {1'b0, len_reg});
    assign sts.tail_match = (rx_byte == tail_reg);
    assign sts.emit_last  = (cnt_reg == (len_reg - 6'd1));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // byte 1 flags are stale for one-byte frames; the length check hides them
    assign key_valid = (len_reg >= 6'd2) && b0_fn_reg && b1_le1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= lpfr_pkg::HEADER_RESET;
            tail_reg   <= lpfr_pkg::TAIL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lpfr_pkg::CFG_HEADER: header_reg <= cfg_data;
                lpfr_pkg::CFG_TAIL:   tail_reg   <= cfg_data;
                default:              header_reg <= header_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 6'd0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            if (cmd.load_len)
            begin
                len_reg <= rx_byte[5:0];
                cnt_reg <= 6'd0;
            end
            else if (cmd.store_byte || cmd.emit_step)
                cnt_reg <= cnt_inc[5:0];
            else if (cmd.start_emit)
                cnt_reg <= 6'd0;
        end
    end

    // capture the key command bytes on the way in
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte && (cnt_reg == 6'd0))
            b0_fn_reg <= (rx_byte == lpfr_pkg::KEY_FUNCTION);
        if (cmd.store_byte && (cnt_reg == 6'd1))
        begin
            b1_le1_reg <= (rx_byte == lpfr_pkg::KEY_OFF) || (rx_byte == lpfr_pkg::KEY_ON);
            b1_one_reg <= (rx_byte == lpfr_pkg::KEY_ON);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
            store_mem[addr] <= rx_byte;
    end

    // the store's read register is the output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            rd_data_reg <= store_mem[addr];
            pos_reg     <= cnt_reg;
            last_reg    <= sts.emit_last;
            kv_reg      <= key_valid;
            kon_reg     <= key_valid && b1_one_reg;
        end
    end

    assign out_valid_next = cmd.emit_step || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid         = out_valid_reg;
    assign payload_byte      = rd_data_reg;
    assign payload_position  = pos_reg;
    assign last_of_frame     = last_reg;
    assign key_command_valid = kv_reg;
    assign key_on            = kon_reg;

endmodule
`default_nettype wire

// File: rtl/length_prefixed_frame_receiver.sv
`default_nettype none
// -----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Receives header / length / payload / tail frames byte by byte and bursts
// out the payload of each good frame with a key command decode.
//
// Input channel (in_valid, in_stall, rx_byte): one serial byte per beat, taken
// at one byte per cycle while framing. Output channel (out_valid, out_stall,
// payload fields): one beat per payload byte, last_of_frame on the final one.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): header byte at
// index 0, tail byte at index 1; cfg_ready is always high.
// The first beat reaches the output register after the matching tail byte is
// taken; the rest follow at one per cycle while out_stall is low. in_stall
// stays high until the last beat is loaded, as the store has one read port.
// A stalled output beat holds; the burst resumes when out_stall drops.
// Bad lengths and wrong tails drop the frame with no output.
// Reset returns to header hunt with header 0xAA and tail 0x55; the payload
// store is not cleared.
// -----------------------------------------------------------------------------
module length_prefixed_frame_receiver
#(
    parameter int BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      payload_byte,
    output logic [5:0]      payload_position,
    output logic            last_of_frame,
    output logic            key_command_valid,
    output logic            key_on,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    lpfr_pkg::cmd_t cmd;
    lpfr_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    lpfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpfr_dp
    #(
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .rx_byte           (rx_byte),
        .cmd               (cmd),
        .sts               (sts),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .payload_byte      (payload_byte),
        .payload_position  (payload_position),
        .last_of_frame     (last_of_frame),
        .key_command_valid (key_command_valid),
        .key_on            (key_on)
    );

    // a burst runs without gaps
    a_burst_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_frame) |=> out_valid)
        else $error("gap inside payload burst");

    // input is held off until the last beat has been issued
    a_stall_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_frame) |-> in_stall)
        else $error("input taken during payload burst");

    a_key_on_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_on) |-> key_command_valid)
        else $error("key_on without valid key command");

endmodule
`default_nettype wire

// File: test/length_prefixed_frame_receiver_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// length_prefixed_frame_receiver_test
// Self-checking bench for the frame receiver. A queue of serial bytes feeds a
// clocked driver. Each accepted byte runs through a local model of the framing
// logic, and that model queues the payload beats a good frame should produce.
// A clocked monitor checks every output beat against the oldest queued beat.
// Header and tail bytes are reprogrammed between phases, including the
// extremes. Both channels see random gaps and stalls, except for one phase
// that runs at full rate.
// -----------------------------------------------------------------------------
module length_prefixed_frame_receiver_test;

    localparam int MAX_LEN         =
        (lpfr_pkg::BUFFER_BYTES_DEFAULT - lpfr_pkg::FRAME_OVERHEAD > lpfr_pkg::LEN_CAP) ?
        lpfr_pkg::LEN_CAP : lpfr_pkg::BUFFER_BYTES_DEFAULT - lpfr_pkg::FRAME_OVERHEAD;
    localparam int IDLE_PERCENT    = 22;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_BYTES     = 55;

    // payload shapes for queue_frame
    localparam int KEY_MODE_RANDOM = 0;
    localparam int KEY_MODE_OFF    = 1;
    localparam int KEY_MODE_ON     = 2;
    localparam int KEY_MODE_BAD    = 3;

    typedef enum logic [1:0] {
        HUNT_HEADER,
        TAKE_LENGTH,
        TAKE_PAYLOAD,
        TAKE_TAIL
    } rx_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] pos;
        logic       last;
        logic       key_valid;
        logic       key_state;
    } frame_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] payload_byte;
    logic [5:0] payload_position;
    logic       last_of_frame;
    logic       key_command_valid;
    logic       key_on;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = lpfr_pkg::CFG_HEADER;
    logic [7:0] cfg_data = 8'h00;

    // framing model state
    rx_phase_t  model_phase = HUNT_HEADER;
    logic [5:0] model_len = '0;
    logic [5:0] model_count = '0;
    logic [7:0] model_store [64];
    logic [7:0] header_cfg = lpfr_pkg::HEADER_RESET;
    logic [7:0] tail_cfg = lpfr_pkg::TAIL_RESET;

    logic [7:0]  rx_queue[$];
    frame_beat_t payload_beats[$];
    int          bytes_queued = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;

    length_prefixed_frame_receiver dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .payload_byte      (payload_byte),
        .payload_position  (payload_position),
        .last_of_frame     (last_of_frame),
        .key_command_valid (key_command_valid),
        .key_on            (key_on),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the framing model by one byte; a good tail queues the payload burst.
    function automatic void frame_step(input logic [7:0] b);
        logic        key_ok;
        logic        key_state;
        frame_beat_t beat;
        begin
            case (model_phase)
                HUNT_HEADER:
                begin
                    if (b == header_cfg)
                        model_phase = TAKE_LENGTH;
                end
                TAKE_LENGTH:
                begin
                    // compare the full byte so large values cannot wrap into range
                    if (b != 8'd0 && int'(b) <= MAX_LEN)
                    begin
                        model_len   = b[5:0];
                        model_count = '0;
                        model_phase = TAKE_PAYLOAD;
                    end
                    else
                        model_phase = HUNT_HEADER;
                end
                TAKE_PAYLOAD:
                begin
                    model_store[model_count] = b;
                    model_count = model_count + 6'd1;
                    if (model_count >= model_len)
                        model_phase = TAKE_TAIL;
                end
                default:
                begin
                    if (b == tail_cfg)
                    begin
                        key_ok = (model_len >= 6'd2) &&
                                 (model_store[0] == lpfr_pkg::KEY_FUNCTION) &&
                                 (model_store[1] == lpfr_pkg::KEY_OFF ||
                                  model_store[1] == lpfr_pkg::KEY_ON);
                        key_state = key_ok && (model_store[1] == lpfr_pkg::KEY_ON);
                        for (int i = 0; i < int'(model_len); i++)
                        begin
                            beat.data      = model_store[i];
                            beat.pos       = 6'(i);
                            beat.last      = (i + 1 == int'(model_len));
                            beat.key_valid = key_ok;
                            beat.key_state = key_state;
                            payload_beats.push_back(beat);
                        end
                    end
                    // a wrong tail is dropped and never looked at as a header
                    model_phase = HUNT_HEADER;
                end
            endcase
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        begin
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        end
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                frame_step(rx_byte);
            // hold a stalled beat; otherwise load the next byte or idle
            if (!in_valid || !in_stall)
            begin
                if (rx_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    rx_byte  <= rx_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // payload monitor
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (payload_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual byte %0d pos %0d",
                             $time, payload_byte, payload_position);
                    mismatches++;
                end
                else
                begin
                    want = payload_beats.pop_front();
                    check_field("payload_byte", want.data, payload_byte);
                    check_field("payload_position", want.pos, payload_position);
                    check_field("last_of_frame", want.last, last_of_frame);
                    check_field("key_command_valid", want.key_valid, key_command_valid);
                    check_field("key_on", want.key_state, key_on);
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("length_prefixed_frame_receiver verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_rx(input logic [7:0] b);
        begin
            rx_queue.push_back(b);
            bytes_queued++;
        end
    endtask

    task automatic queue_frame(input int len, input bit good_tail, input int key_mode);
        logic [7:0] b;
        begin
            push_rx(header_cfg);
            push_rx(8'(len));
            for (int i = 0; i < len; i++)
            begin
                b = 8'($urandom_range(255));
                if (i == 0 && key_mode != KEY_MODE_RANDOM)
                    b = lpfr_pkg::KEY_FUNCTION;
                else if (i == 1 && key_mode == KEY_MODE_OFF)
                    b = lpfr_pkg::KEY_OFF;
                else if (i == 1 && key_mode == KEY_MODE_ON)
                    b = lpfr_pkg::KEY_ON;
                else if (i == 1 && key_mode == KEY_MODE_BAD)
                    b = 8'($urandom_range(2, 255));
                else if ($urandom_range(7) == 0)
                    b = header_cfg;
                push_rx(b);
            end
            push_rx(good_tail ? tail_cfg : tail_cfg ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic queue_random_traffic(input int n_bytes);
        int target;
        int pick;
        int len;
        begin
            target = bytes_queued + n_bytes;
            while (bytes_queued < target)
            begin
                pick = $urandom_range(99);
                len  = ($urandom_range(19) == 0) ? $urandom_range(MAX_LEN - 8, MAX_LEN) :
                                                   $urandom_range(1, 8);
                if (pick < 70)
                    queue_frame(len, 1'b1, ($urandom_range(1) == 0) ? KEY_MODE_RANDOM :
                                           $urandom_range(KEY_MODE_OFF, KEY_MODE_BAD));
                else if (pick < 78)
                begin
                    push_rx(header_cfg);
                    push_rx(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(MAX_LEN + 1, 255)));
                end
                else if (pick < 88)
                    queue_frame(len, 1'b0, $urandom_range(KEY_MODE_RANDOM, KEY_MODE_BAD));
                else
                    repeat ($urandom_range(1, 3)) push_rx(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        begin
            while (rx_queue.size() != 0 || in_valid || payload_beats.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // Write header then tail back to back; valid stays high between the two beats.
    task automatic write_delimiters(input logic [7:0] hdr, input logic [7:0] tl);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= lpfr_pkg::CFG_HEADER;
            cfg_data  <= hdr;
            do @(posedge clk); while (!cfg_ready);
            header_cfg = hdr;
            cfg_index <= lpfr_pkg::CFG_TAIL;
            cfg_data  <= tl;
            do @(posedge clk); while (!cfg_ready);
            tail_cfg = tl;
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise while hunting, bad lengths, no wrap of large lengths
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx(header_cfg);
        push_rx(8'd0);
        push_rx(header_cfg);
        push_rx(8'(MAX_LEN + 1));
        push_rx(header_cfg);
        push_rx(8'hC2);
        push_rx(8'h01);
        push_rx(8'h01);
        push_rx(tail_cfg);
        push_rx(header_cfg);
        push_rx(header_cfg);
        // shortest and longest frames, each key decode, wrong tail
        queue_frame(1, 1'b1, KEY_MODE_RANDOM);
        queue_frame(2, 1'b1, KEY_MODE_ON);
        queue_frame(2, 1'b1, KEY_MODE_OFF);
        queue_frame(3, 1'b1, KEY_MODE_BAD);
        queue_frame(2, 1'b0, KEY_MODE_ON);
        // a wrong tail equal to the header must not open a frame
        push_rx(header_cfg);
        push_rx(8'd2);
        push_rx(8'h01);
        push_rx(8'h01);
        push_rx(header_cfg);
        push_rx(8'd2);
        push_rx(lpfr_pkg::KEY_FUNCTION);
        push_rx(lpfr_pkg::KEY_ON);
        push_rx(tail_cfg);
        queue_frame(MAX_LEN, 1'b1, KEY_MODE_OFF);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        write_delimiters(8'h00, 8'hFF);
        steady = 1'b1;
        queue_frame(2, 1'b1, KEY_MODE_ON);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();
        steady = 1'b0;

        write_delimiters(8'hFF, 8'h00);
        queue_frame(MAX_LEN, 1'b1, KEY_MODE_RANDOM);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        // header and tail share one value
        write_delimiters(8'h5A, 8'h5A);
        queue_random_traffic(PHASE_BYTES);
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("length_prefixed_frame_receiver verification clean");
        else
            $display("length_prefixed_frame_receiver verification failed");
        $finish;
    end

endmodule

// File: length_prefixed_frame_receiver.f
rtl/lpfr_pkg.sv
rtl/lpfr_ctrl.sv
rtl/lpfr_dp.sv
rtl/length_prefixed_frame_receiver.sv
test/length_prefixed_frame_receiver_test.sv
